// ===== design/crcfr_pkg.sv =====
// shared types and constants for the crc16 frame receiver
package crcfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [7:0]  TRAILER     = 8'hFF;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [15:0] CRC_TOPBIT  = 16'h8000;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_CMD     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6,
    PH_TRAILER = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_PAYLOAD   = 3'd1,
    ST_ACCEPT    = 3'd2,
    ST_CRC_ERR   = 3'd3,
    ST_TRAIL_ERR = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] command;
    logic [7:0] frame_length;
  } result_t;

endpackage

// ===== design/crcfr_crc8.sv =====
// byte-wide crc-16 update, msb first, polynomial 0x8005
module crcfr_crc8 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import crcfr_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== design/crcfr_in_reg.sv =====
// input register stage holding one received byte
module crcfr_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       held_valid,
  input  logic       held_take,
  output logic [7:0] held_byte
);
  import crcfr_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || held_take;
  assign held_valid = valid_r;
  assign held_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (held_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== design/crcfr_parser.sv =====
// frame parser state machine with running crc and per-byte result
module crcfr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output crcfr_pkg::result_t   result
);
  import crcfr_pkg::*;

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [7:0]  count_r;
  logic [7:0]  count_nxt;
  logic [7:0]  length_r;
  logic [7:0]  command_r;
  logic [15:0] crc_r;
  logic [7:0]  crc_hi_r;
  logic [15:0] crc_base;
  logic [15:0] crc_fed;
  logic        crc_load;
  logic        crc_match;

  // hunt always restarts from the init value
  assign crc_base  = (phase_r == PH_HUNT) ? CRC_INIT : crc_r;
  assign count_nxt = count_r + 8'd1;
  assign crc_match = ({crc_hi_r, rx_byte} == crc_r);

  crcfr_crc8 u_crc8 (
    .crc_in  (crc_base),
    .data_in (rx_byte),
    .crc_out (crc_fed)
  );

  // next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT:    phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      PH_SYNC2:   phase_nxt = (rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT;
      PH_LEN:     phase_nxt = PH_CMD;
      PH_CMD:     phase_nxt = (length_r == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
      PH_PAYLOAD: phase_nxt = (count_nxt == length_r) ? PH_CRC_HI : PH_PAYLOAD;
      PH_CRC_HI:  phase_nxt = PH_CRC_LO;
      PH_CRC_LO:  phase_nxt = crc_match ? PH_TRAILER : PH_HUNT;
      PH_TRAILER: phase_nxt = PH_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    result   = '0;
    crc_load = 1'b0;
    unique case (phase_r)
      PH_HUNT:  crc_load = (rx_byte == SYNC_FIRST);
      PH_SYNC2: crc_load = (rx_byte == SYNC_SECOND);
      PH_LEN:   crc_load = 1'b1;
      PH_CMD:   crc_load = 1'b1;
      PH_PAYLOAD: begin
        crc_load             = 1'b1;
        result.status        = ST_PAYLOAD;
        result.payload_byte  = rx_byte;
        result.payload_index = count_r;
      end
      PH_CRC_HI: ;
      PH_CRC_LO: begin
        if (!crc_match) begin
          result.status = ST_CRC_ERR;
        end
      end
      PH_TRAILER: begin
        result.status = (rx_byte == TRAILER) ? ST_ACCEPT : ST_TRAIL_ERR;
      end
    endcase
    if (result.status != ST_NONE) begin
      result.command      = command_r;
      result.frame_length = length_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      count_r   <= 8'd0;
      length_r  <= 8'd0;
      command_r <= 8'd0;
      crc_r     <= CRC_INIT;
      crc_hi_r  <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      if (crc_load) begin
        crc_r <= crc_fed;
      end
      if (phase_r == PH_LEN) begin
        length_r <= rx_byte;
      end
      if (phase_r == PH_CMD) begin
        command_r <= rx_byte;
        count_r   <= 8'd0;
      end
      if (phase_r == PH_PAYLOAD) begin
        count_r <= count_nxt;
      end
      if (phase_r == PH_CRC_HI) begin
        crc_hi_r <= rx_byte;
      end
    end
  end

endmodule

// ===== design/crc16_frame_receiver_unit.sv =====
// top level of the crc16 frame receiver: input register, parser, result register
// each byte's result is formed by the parser from the input register and registered in
// the result register, where it waits until it transfers out on out_tready
// throughput: one byte per cycle; input stalls only while a result waits on out_tready
// every input byte gives exactly one result transfer
// reset (rst_n low, synchronous) empties both registers and returns the parser
// to sync hunt with the crc at 0xffff
module crc16_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [15:8] payload_index,
                                  // [23:16] command, [31:24] frame_length
  output logic [2:0]  out_tuser   // [2:0] status
);
  import crcfr_pkg::*;

  logic    held_valid;
  logic    held_take;
  logic    out_free;
  logic [7:0] held_byte;
  result_t result;
  result_t result_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign held_take = held_valid && out_free;

  crcfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .held_valid (held_valid),
    .held_take  (held_take),
    .held_byte  (held_byte)
  );

  crcfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (held_take),
    .rx_byte (held_byte),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (held_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (held_take) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = result_r.status;
  assign out_tdata  = {result_r.frame_length, result_r.command,
                       result_r.payload_index, result_r.payload_byte};

  // no result is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // status codes above bad trailer never appear
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= 3'd4))
    else $error("status out of range");

  // byte and index fields are zero unless a payload byte is reported
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_PAYLOAD) |-> (out_tdata[15:0] == 16'h0000))
    else $error("payload fields set without payload status");

  // frame fields are zero when nothing is reported
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_NONE) |-> (out_tdata == 32'h0))
    else $error("frame fields set with no status");

endmodule
